### design/lpg_pkg.sv
// ---------------------------------------------------------------------------
// lpg_pkg: shared types and constants of the line point generator
// Coordinate width, command codes, channel words and divider status.
// ---------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int STEP_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_word_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last;
  } point_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sta_t;

endpackage

### design/line_point_generator.sv
// ---------------------------------------------------------------------------
// line_point_generator: line segment rasterizer
// Start loads two endpoints and gives the first point; each advance gives
// the next point along the major axis, minor axis by exact truncated ratio.
// ---------------------------------------------------------------------------
//
//  channel  | word          | handshake
//  ---------+---------------+----------------------------------------------
//  line     | line_word_t   | line_valid / line_stall, taken when !stall
//  point    | point_word_t  | point_valid / point_stall, taken when !stall
//
//  A word that makes a point passes S_MUL (multiply and start the divider),
//  S_DIV (the shared radix-2 divider, one quotient bit a cycle, then its done
//  flag) and S_DONE (form the point into the result register once the output
//  is free). line_stall drops as that point is registered, so the next word is
//  taken only then. An advance with no line active is dropped on acceptance.
//  line_stall is high while a word is in work; the finished point sits in
//  its own register, so a new word is taken while that point is stalled.
//  Reset (rst, synchronous) leaves no line active and no point pending.
//
module line_point_generator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  output logic                 line_stall,
  input  lpg_pkg::line_word_t  line_word,
  output logic                 point_valid,
  input  logic                 point_stall,
  output lpg_pkg::point_word_t point_word
);
  import lpg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // per-line constants, set on start
  coord_t               s0;         // major start coordinate
  coord_t               m0;         // minor start coordinate
  coord_t               span;       // |major delta|
  coord_t               dm_mag;     // |minor delta|
  logic                 dm_neg;     // minor runs downward
  logic                 up;         // major runs upward
  logic                 major_is_y;
  logic                 line_active;
  logic [STEP_BITS-1:0] step_count;

  // start decode
  coord_t dx, dy, n_s0, n_e0, n_m0, n_m1;
  logic   n_myy;

  // datapath
  logic                 take;
  logic                 div_start;
  logic [PROD_BITS-1:0] product;
  coord_t               quo;
  div_sta_t             div_sta;
  coord_t               q_eff, major, minor;
  logic                 is_last;
  logic                 out_free;

  assign take       = line_valid && !line_stall;
  assign line_stall = (state != S_IDLE);

  always_comb begin
    dx    = (line_word.end_x >= line_word.start_x) ? line_word.end_x - line_word.start_x
                                                   : line_word.start_x - line_word.end_x;
    dy    = (line_word.end_y >= line_word.start_y) ? line_word.end_y - line_word.start_y
                                                   : line_word.start_y - line_word.end_y;
    n_myy = (dy > dx);
    n_s0  = n_myy ? line_word.start_y : line_word.start_x;
    n_e0  = n_myy ? line_word.end_y   : line_word.end_x;
    n_m0  = n_myy ? line_word.start_x : line_word.start_y;
    n_m1  = n_myy ? line_word.end_x   : line_word.end_y;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && (line_word.cmd == CMD_START || line_active)) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_sta.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line constants and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
      major_is_y <= 1'b0;
    end else if (state == S_IDLE && take) begin
      if (line_word.cmd == CMD_START) begin
        step_count <= '0;
        major_is_y <= n_myy;
      end else if (line_active) begin
        step_count <= step_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && take && line_word.cmd == CMD_START) begin
      s0     <= n_s0;
      m0     <= n_m0;
      span   <= n_myy ? dy : dx;
      up     <= (n_e0 >= n_s0);
      dm_neg <= (n_m1 < n_m0);
      dm_mag <= (n_m1 >= n_m0) ? n_m1 - n_m0 : n_m0 - n_m1;
    end
  end

  // |minor delta| * steps, straight into the divider's remainder register
  assign div_start = (state == S_MUL);
  assign product   = PROD_BITS'(dm_mag) * PROD_BITS'(step_count[COORD_BITS-1:0]);

  lpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span),
    .quotient (quo),
    .sta      (div_sta)
  );

  // point assembly; a zero span means a single point
  always_comb begin
    q_eff   = (span == '0) ? '0 : quo;
    minor   = dm_neg ? m0 - q_eff : m0 + q_eff;
    major   = up ? s0 + step_count[COORD_BITS-1:0] : s0 - step_count[COORD_BITS-1:0];
    is_last = (step_count >= {1'b0, span});
  end

  assign out_free = !point_valid || !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      line_active <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        point_valid <= 1'b1;
        line_active <= !is_last;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      point_word.point_x <= major_is_y ? minor : major;
      point_word.point_y <= major_is_y ? major : minor;
      point_word.last    <= is_last;
    end
  end

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_sta.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_sta.busy || div_sta.done)
    else $error("waiting on an idle divider");

  a_point_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> $past(state == S_DONE))
    else $error("point word appeared without a finished computation");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_word.last |-> !line_active)
    else $error("line still active after its last point");

endmodule

### design/lpg_div.sv
// ---------------------------------------------------------------------------
// lpg_div: radix-2 restoring divider
// Unsigned product / span, one quotient bit per cycle. The caller guarantees
// that the quotient fits in COORD_BITS bits.
// ---------------------------------------------------------------------------
module lpg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpg_pkg::PROD_BITS-1:0] dividend,
  input  lpg_pkg::coord_t              divisor,
  output lpg_pkg::coord_t              quotient,
  output lpg_pkg::div_sta_t            sta
);
  import lpg_pkg::*;

  localparam int CNT_BITS = $clog2(COORD_BITS);

  logic [PROD_BITS-1:0] rem;
  logic [PROD_BITS-1:0] dsh;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic                 done;
  logic                 fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(COORD_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // divisor aligned to the top quotient bit, walked down one place a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {1'b0, divisor, {(COORD_BITS-1){1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[COORD_BITS-2:0], fits};
    end
  end

  assign sta.busy = busy;
  assign sta.done = done;

endmodule

### dv/tb_line_point_generator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_line_point_generator: self-checking bench for the line rasterizer
// Feeds start/advance words through the line channel, predicts every point
// in a local model of the rasterizer and compares each point word that
// leaves the block, with random idling and stalls on both channels.
// ---------------------------------------------------------------------------
module tb_line_point_generator;
  import lpg_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;     // quiet tail after the last point
  localparam int LONG_HOLD    = 400;    // receiver hold-off, in cycles
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 450;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  // One queued line word plus the pacing flags that ride with it.
  typedef struct {
    line_word_t word;
    bit         calm;        // no gaps on either side while this word is out
    bit         hold_sink;   // start the long receiver hold-off when offered
    bit         wait_drain;  // hold back until every pending point is out
  } line_job_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        line_valid  = 1'b0;
  logic        line_stall;
  line_word_t  line_word   = '0;
  logic        point_valid;
  logic        point_stall = 1'b0;
  point_word_t point_word;

  line_job_t   line_jobs[$];
  point_word_t expected_points[$];

  // Local copy of the rasterizer state (reset values are all zero).
  coord_t               ln_sx = '0, ln_sy = '0, ln_ex = '0, ln_ey = '0;
  logic [STEP_BITS-1:0] ln_steps  = '0;
  logic                 ln_ymaj   = 1'b0;
  logic                 ln_active = 1'b0;

  // Pacing shared between driver and monitor; written only with NBAs.
  logic calm_mode = 1'b0;
  int   hold_req  = 0;

  // Generator flags; next_hold and next_drain are consumed by the next queued word.
  bit gen_calm   = 1'b0;
  bit next_hold  = 1'b0;
  bit next_drain = 1'b0;

  int cycles         = 0;
  int mismatches     = 0;
  int words_taken    = 0;
  int starts_taken   = 0;
  int points_checked = 0;
  int lines_finished = 0;

  always begin
    #6 clk = ~clk;
  end

  line_point_generator dut (
    .clk         (clk),
    .rst         (rst),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line_word   (line_word),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_word  (point_word)
  );

  // -------------------------------------------------------------------------
  // Point model
  // -------------------------------------------------------------------------

  // Current point of the active line. Major axis moves one per step toward
  // the end; minor axis is start + delta_minor * steps / delta_major with
  // the quotient truncated toward zero (SV signed division does that).
  function automatic point_word_t line_point();
    longint      s0, e0, m0, m1, n, k, maj, mnr;
    point_word_t p;
    s0 = ln_ymaj ? longint'(ln_sy) : longint'(ln_sx);
    e0 = ln_ymaj ? longint'(ln_ey) : longint'(ln_ex);
    m0 = ln_ymaj ? longint'(ln_sx) : longint'(ln_sy);
    m1 = ln_ymaj ? longint'(ln_ex) : longint'(ln_ey);
    n  = (e0 >= s0) ? e0 - s0 : s0 - e0;
    k  = longint'(ln_steps);
    if (n == 0) begin
      maj    = s0;
      mnr    = m0;
      p.last = 1'b1;
    end else begin
      maj    = (e0 >= s0) ? s0 + k : s0 - k;
      mnr    = m0 + ((m1 - m0) * k) / n;
      p.last = (k >= n);
    end
    p.point_x = ln_ymaj ? coord_t'(mnr) : coord_t'(maj);
    p.point_y = ln_ymaj ? coord_t'(maj) : coord_t'(mnr);
    return p;
  endfunction

  // Apply one accepted line word to the model and queue the point it makes.
  function automatic void rasterize_word(line_word_t w);
    coord_t      dx, dy;
    point_word_t p;
    if (w.cmd == CMD_START) begin
      ln_sx    = w.start_x;
      ln_sy    = w.start_y;
      ln_ex    = w.end_x;
      ln_ey    = w.end_y;
      dx       = (ln_ex >= ln_sx) ? ln_ex - ln_sx : ln_sx - ln_ex;
      dy       = (ln_ey >= ln_sy) ? ln_ey - ln_sy : ln_sy - ln_ey;
      ln_ymaj  = (dy > dx);              // ties stay on x
      ln_steps = '0;
      p        = line_point();
      ln_active = !p.last;
      expected_points.push_back(p);
      starts_taken++;
    end else if (ln_active) begin
      ln_steps  = ln_steps + 1'b1;
      p         = line_point();
      ln_active = !p.last;
      expected_points.push_back(p);
    end
    // advance with no line: dropped, nothing expected
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Sender gap: mostly none, some short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Coordinates lean on the range ends now and then.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    else if (r < 10) return COORD_MAX;
    else return $urandom_range(0, COORD_MAX);
  endfunction

  task automatic add_word(input logic cmd, input int sx, sy, ex, ey);
    line_job_t j;
    j.word.cmd     = cmd;
    j.word.start_x = coord_t'(sx);
    j.word.start_y = coord_t'(sy);
    j.word.end_x   = coord_t'(ex);
    j.word.end_y   = coord_t'(ey);
    j.calm         = gen_calm;
    j.hold_sink    = next_hold;
    j.wait_drain   = next_drain;
    next_hold      = 1'b0;
    next_drain     = 1'b0;
    line_jobs.push_back(j);
  endtask

  // Advance words carry random junk in the endpoint fields.
  task automatic add_advance();
    add_word(CMD_ADVANCE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  // A start plus its advances. Mostly short lines; some are cut off by the
  // next start, some get extra advances past the end (dropped, not counted).
  task automatic add_line(output int made);
    int len, mlen, smaj, smin, emaj, emin, r, advances;
    bit ymaj;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 80) len = $urandom_range(1, 8);
    else if (r < 96) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 150);
    mlen = $urandom_range(0, len);
    ymaj = 1'($urandom_range(0, 1));
    smaj = pick_coord();
    smin = pick_coord();
    emaj = $urandom_range(0, 1) ? smaj + len : smaj - len;
    if (emaj > COORD_MAX || emaj < 0) emaj = 2 * smaj - emaj;
    emin = $urandom_range(0, 1) ? smin + mlen : smin - mlen;
    if (emin > COORD_MAX || emin < 0) emin = 2 * smin - emin;
    if (ymaj) add_word(CMD_START, smin, smaj, emin, emaj);
    else      add_word(CMD_START, smaj, smin, emaj, emin);
    r        = $urandom_range(0, 99);
    advances = (r < 15) ? $urandom_range(0, len) : len;
    repeat (advances) add_advance();
    made = 1 + advances;
    if (r >= 85) repeat ($urandom_range(1, 2)) add_advance();
  endtask

  // -------------------------------------------------------------------------
  // Line driver: presents queued words, predicts on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : line_driver
    line_job_t nx;
    logic      took;
    int        gap_left;
    if (rst) begin
      line_valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = line_valid && !line_stall;
      if (took) begin
        rasterize_word(line_word);
        words_taken++;
      end
      // Payload only moves once the held word is gone.
      if (!line_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          line_valid <= 1'b0;
        end else if (line_jobs.size() != 0 &&
                     !(line_jobs[0].wait_drain && expected_points.size() != 0)) begin
          nx = line_jobs.pop_front();
          line_word  <= nx.word;
          line_valid <= 1'b1;
          calm_mode  <= nx.calm;
          if (nx.hold_sink) hold_req <= hold_req + 1;
          gap_left = nx.calm ? 0 : gap_len();
        end else begin
          line_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Point monitor: checks each accepted point word, drives point_stall
  // -------------------------------------------------------------------------
  function automatic void check_point(point_word_t got);
    point_word_t want;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected point: x=%0d y=%0d last=%0b",
                 $realtime, got.point_x, got.point_y, got.last);
    end else begin
      want = expected_points.pop_front();
      points_checked++;
      if (got.last) lines_finished++;
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] point %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $realtime, points_checked, want.point_x, want.point_y, want.last,
                   got.point_x, got.point_y, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin : point_monitor
    int hold_seen;
    int hold_left;
    int stall_left;
    if (rst) begin
      point_stall <= 1'b0;
      hold_seen  = 0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (point_valid && !point_stall) check_point(point_word);
      // long hold-off: block fills up and has to stall the line channel
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        point_stall <= 1'b1;
      end else if (calm_mode) begin
        stall_left = 0;
        point_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        point_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 35) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 29)
                                                 : $urandom_range(0, 2);
        point_stall <= 1'b1;
      end else begin
        point_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d points still pending",
               cycles, expected_points.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    int planned;
    int made;
    bit hold_done;
    bit drain_done;
    planned    = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    // Directed part.
    add_word(CMD_ADVANCE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX); // no line yet
    add_word(CMD_START, 0, 0, 0, 0);                          // single point
    add_word(CMD_ADVANCE, 0, 0, 0, 0);                        // line already done
    add_word(CMD_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_word(CMD_START, 0, 0, 3, 1);                          // x major, upward
    repeat (3) add_advance();
    add_advance();                                            // past the end
    add_word(CMD_START, COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1);
    repeat (2) add_advance();                                 // x major, downward
    add_word(CMD_START, 0, COORD_MAX, 1, COORD_MAX - 3);      // y major, downward
    repeat (3) add_advance();
    add_word(CMD_START, 10, 10, 13, 7);                       // tie goes to x
    add_advance();                                            // left active
    add_word(CMD_START, 0, COORD_MAX, COORD_MAX, 0);          // full-span, minor falls
    repeat (2) add_advance();
    add_word(CMD_START, COORD_MAX, 0, 0, COORD_MAX);          // restart while active
    add_advance();
    add_word(CMD_START, 2005, 100, 2000, 90);                 // negative minor, truncation
    repeat (3) add_advance();

    // Random part: mostly whole or cut-off lines, some raw noise words.
    while (planned < RANDOM_WORDS) begin
      gen_calm = (planned >= 150 && planned < 210) || (planned >= 380 && planned < 420);
      if (!hold_done && planned >= 160) begin
        next_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && planned >= 300) begin
        next_drain = 1'b1;
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) begin
        add_word(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX));
      end else begin
        add_line(made);
        planned += made;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for all words taken, all points out, then a quiet tail.
    while (line_jobs.size() != 0 || line_valid) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d line words taken (%0d starts), %0d points checked, %0d lines ended",
             words_taken, starts_taken, points_checked, lines_finished);
    $display("Both channels idled and stalled, incl. a %0d-cycle output hold and a full drain",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
